// ===== hdl/uart_pkg.sv =====
// Shared types and constants of the UART 8N1 transceiver.
package uart_pkg;

  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 16;
  localparam int OutDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TX_BIT_TICKS  = 2'd0,
    REG_RX_BIT_TICKS  = 2'd1,
    REG_RX_HALF_TICKS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_out_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } rx_out_t;

endpackage

// ===== hdl/uart_tx.sv =====
// UART transmitter: per-tick frame sequencer for start, data and stop bits.
module uart_tx #(
  parameter int DATA_BITS = 8,
  parameter int PERIOD_W  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       req_i,
  input  logic [uart_pkg::ByteW-1:0] byte_i,
  input  logic [PERIOD_W-1:0]        period_i,
  output uart_pkg::tx_out_t          out_o
);
  import uart_pkg::*;

  localparam int CntW = $clog2(DATA_BITS);

  typedef enum logic [3:0] {
    TX_IDLE  = 4'b0001,
    TX_START = 4'b0010,
    TX_DATA  = 4'b0100,
    TX_STOP  = 4'b1000
  } tx_phase_e;

  tx_phase_e            phase_q, phase_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic [PERIOD_W-1:0]  timer_q, timer_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 level_q, level_d;

  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    timer_d = timer_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    case (phase_q)
      TX_IDLE: begin
      end
      TX_START: begin
        if (timer_q != '0) begin
          timer_d = timer_q - 1'b1;
        end else begin
          timer_d = period_i - 1'b1;
          level_d = shift_q[0];
          shift_d = shift_q >> 1;
          cnt_d   = '0;
          phase_d = TX_DATA;
        end
      end
      TX_DATA: begin
        if (timer_q != '0) begin
          timer_d = timer_q - 1'b1;
        end else begin
          timer_d = period_i - 1'b1;
          if (cnt_q == CntW'(DATA_BITS - 1)) begin
            level_d = 1'b1;
            phase_d = TX_STOP;
          end else begin
            level_d = shift_q[0];
            shift_d = shift_q >> 1;
            cnt_d   = cnt_q + 1'b1;
          end
        end
      end
      TX_STOP: begin
        if (timer_q != '0) begin
          timer_d = timer_q - 1'b1;
        end else begin
          phase_d = TX_IDLE;
          level_d = 1'b1;
        end
      end
      default: begin
        phase_d = TX_IDLE;
        level_d = 1'b1;
      end
    endcase
    // a request on the tick the stop bit ends is taken at once
    if (phase_d == TX_IDLE && req_i) begin
      shift_d = DATA_BITS'(byte_i);
      phase_d = TX_START;
      level_d = 1'b0;
      timer_d = period_i - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= TX_IDLE;
      shift_q <= '0;
      timer_q <= '0;
      cnt_q   <= '0;
      level_q <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      timer_q <= timer_d;
      cnt_q   <= cnt_d;
      level_q <= level_d;
    end
  end

  assign out_o.line = level_d;
  assign out_o.busy = (phase_d != TX_IDLE);

endmodule

// ===== hdl/uart_rx.sv =====
// UART receiver: start hunt, mid-bit sampling and byte report per tick.
module uart_rx #(
  parameter int DATA_BITS = 8,
  parameter int PERIOD_W  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                line_i,
  input  logic [PERIOD_W-1:0] period_i,
  input  logic [PERIOD_W-1:0] half_i,
  output uart_pkg::rx_out_t   out_o
);
  import uart_pkg::*;

  localparam int IdxW = $clog2(DATA_BITS + 1);
  localparam int SelW = $clog2(DATA_BITS);

  typedef enum logic [2:0] {
    RX_HUNT = 3'b001,
    RX_DATA = 3'b010,
    RX_LAST = 3'b100
  } rx_phase_e;

  rx_phase_e            phase_q, phase_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic [PERIOD_W:0]    timer_q, timer_d;
  logic                 done;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    timer_d = timer_q;
    done    = 1'b0;
    case (phase_q)
      RX_DATA: begin
        timer_d = timer_q - 1'b1;
        if (timer_q == (PERIOD_W+1)'(1)) begin
          if (line_i) begin
            shift_d[idx_q[SelW-1:0]] = 1'b1;
          end
          idx_d   = idx_q + 1'b1;
          timer_d = {1'b0, period_i};
          if (idx_q == IdxW'(DATA_BITS - 1)) begin
            phase_d = RX_LAST;
          end
        end
      end
      RX_LAST: begin
        timer_d = timer_q - 1'b1;
        if (timer_q == (PERIOD_W+1)'(1)) begin
          done    = 1'b1;
          phase_d = RX_HUNT;
        end
      end
      default: begin
        phase_d = RX_HUNT;
        if (!line_i) begin
          phase_d = RX_DATA;
          idx_d   = '0;
          shift_d = '0;
          timer_d = {1'b0, period_i} + {1'b0, half_i};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= RX_HUNT;
      idx_q   <= '0;
      shift_q <= '0;
      timer_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      timer_q <= timer_d;
    end
  end

  assign out_o.valid = done;
  assign out_o.data  = done ? ByteW'(shift_q) : '0;

endmodule

// ===== hdl/uart_8n1_transceiver_unit.sv =====
// Top level of the UART 8N1 transceiver: config registers, tick stream, result register.
//
// Each input item is one time tick carrying the sampled receive level, a send request
// and the byte to send; each accepted tick yields exactly one result item with the
// transmit level, the busy flag and, on completion, a received byte. One tick is
// accepted every clock cycle: the transmit and receive state advance in a single
// combinational pass and the result lands in one output register, so it appears in the
// cycle after the tick is accepted, and s_axis_tready stays high unless that register
// holds an item that m_axis_tready has not taken. Bit periods are tick counts from the
// configuration registers, masked to the narrower of TIMER_WIDTH and CfgDataW bits; a
// period of zero acts as one, and a new value takes effect the next time a timer loads.
module uart_8n1_transceiver_unit #(
  parameter int DATA_BITS   = 8,
  parameter int TIMER_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uart_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [uart_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // rx_line, tx_valid, tx_byte[7:0], zero pad
  input  logic [uart_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tx_line, tx_busy, rx_valid, rx_byte[7:0], zero pad
  output logic [uart_pkg::OutDataW-1:0] m_axis_tdata
);
  import uart_pkg::*;

  localparam int PeriodW = (TIMER_WIDTH < CfgDataW) ? TIMER_WIDTH : CfgDataW;

  logic [CfgDataW-1:0] tx_bit_q, rx_bit_q, rx_half_q;
  logic [PeriodW-1:0]  tx_period, rx_period, rx_half;
  logic                s_fire;
  tx_out_t             tx_out;
  rx_out_t             rx_out;
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_bit_q  <= CfgDataW'(16);
      rx_bit_q  <= CfgDataW'(16);
      rx_half_q <= CfgDataW'(8);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_TX_BIT_TICKS:  tx_bit_q  <= cfg_wdata_i;
        REG_RX_BIT_TICKS:  rx_bit_q  <= cfg_wdata_i;
        REG_RX_HALF_TICKS: rx_half_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign tx_period = (tx_bit_q[PeriodW-1:0] == '0) ? PeriodW'(1) : tx_bit_q[PeriodW-1:0];
  assign rx_period = (rx_bit_q[PeriodW-1:0] == '0) ? PeriodW'(1) : rx_bit_q[PeriodW-1:0];
  assign rx_half   = rx_half_q[PeriodW-1:0];

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  uart_tx #(
    .DATA_BITS (DATA_BITS),
    .PERIOD_W  (PeriodW)
  ) u_tx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s_fire),
    .req_i    (s_axis_tdata[1]),
    .byte_i   (s_axis_tdata[9:2]),
    .period_i (tx_period),
    .out_o    (tx_out)
  );

  uart_rx #(
    .DATA_BITS (DATA_BITS),
    .PERIOD_W  (PeriodW)
  ) u_rx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s_fire),
    .line_i   (s_axis_tdata[0]),
    .period_i (rx_period),
    .half_i   (rx_half),
    .out_o    (rx_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      m_data_q <= OutDataW'({rx_out.data, rx_out.valid, tx_out.busy, tx_out.line});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // idle transmitter holds the line high
  a_idle_line_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("tx line low while transmitter idle");

  // a held result blocks the next tick
  a_hold_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("tick accepted while result register is full");

  // a byte report returns the receiver to hunting
  a_rx_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && rx_out.valid |=> !rx_out.valid)
    else $error("received byte reported on consecutive ticks");

endmodule
